@@ rtl/pfa_pkg.sv @@
// ---------------------------------------------------------------------------
// Primitive-to-face assembly package
// Register map, mode and face-kind codes, and the structs shared between the
// configuration block, the assembler and the face emitter.
// ---------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  // Widths fixed by the stream fields.
  localparam int IDX_IN_BITS = 16;
  localparam int OFFS_BITS   = 32;
  localparam int CNT_BITS    = 16;
  localparam int MODE_BITS   = 3;
  localparam int KIND_BITS   = 2;
  localparam int REG_ADDR_BITS = 2;

  // Vertex count runs to its top value and then steps back by twelve.
  localparam logic [CNT_BITS-1:0] CNT_TOP  = 16'hFFFF;
  localparam logic [CNT_BITS-1:0] CNT_BACK = 16'hFFF4;

  // Primitive modes. Code 7 is handled like points.
  localparam logic [MODE_BITS-1:0] MODE_LINES     = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_LINE_STRIP = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_TRIS      = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_TRI_STRIP = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_FAN       = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_QUADS     = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_POINTS    = 3'd6;

  // Face kinds on the result stream.
  localparam logic [KIND_BITS-1:0] KIND_LINE  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_TRI   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_POINT = 2'd2;

  // Register indexes (word address).
  localparam logic [REG_ADDR_BITS-1:0] REG_MODE    = 2'd0;
  localparam logic [REG_ADDR_BITS-1:0] REG_VTX_OFF = 2'd1;
  localparam logic [REG_ADDR_BITS-1:0] REG_TEX_OFF = 2'd2;
  localparam logic [REG_ADDR_BITS-1:0] REG_NRM_OFF = 2'd3;

  localparam logic [MODE_BITS-1:0] MODE_RESET = MODE_TRIS;

  // Index of a field inside a corner.
  localparam int F_POS = 0;
  localparam int F_TEX = 1;
  localparam int F_NRM = 2;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic [OFFS_BITS-1:0] vtx_off;
    logic [OFFS_BITS-1:0] tex_off;
    logic [OFFS_BITS-1:0] nrm_off;
  } cfg_t;

  // What one vertex beat produces.
  typedef struct packed {
    logic                 has_face;
    logic                 two;
    logic [KIND_BITS-1:0] kind;
  } grp_t;

endpackage

`default_nettype wire

@@ rtl/pfa_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the primitive mode and the three index
// offsets. Writes land on the access cycle; reads are combinational.
// ---------------------------------------------------------------------------
`default_nettype none

module pfa_cfg_regs
  import pfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  logic wr_en;
  logic [REG_ADDR_BITS-1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode    <= MODE_RESET;
      cfg_r.vtx_off <= '0;
      cfg_r.tex_off <= '0;
      cfg_r.nrm_off <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:    cfg_r.mode    <= cfg_pwdata[MODE_BITS-1:0];
        REG_VTX_OFF: cfg_r.vtx_off <= cfg_pwdata;
        REG_TEX_OFF: cfg_r.tex_off <= cfg_pwdata;
        REG_NRM_OFF: cfg_r.nrm_off <= cfg_pwdata;
        default:     ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_idx)
      REG_MODE:    cfg_prdata = {{(32-MODE_BITS){1'b0}}, cfg_r.mode};
      REG_VTX_OFF: cfg_prdata = cfg_r.vtx_off;
      REG_TEX_OFF: cfg_prdata = cfg_r.tex_off;
      REG_NRM_OFF: cfg_prdata = cfg_r.nrm_off;
      default:     cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/pfa_assemble.sv @@
// ---------------------------------------------------------------------------
// Vertex grouping
// Keeps the running vertex count, the last three vertices and the fan anchor,
// and picks the corners of the face or faces that the incoming vertex closes.
// ---------------------------------------------------------------------------
`default_nettype none

module pfa_assemble
  import pfa_pkg::*;
#(
  parameter int VB = 16
)(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_fire,
  input  wire logic [IDX_IN_BITS-1:0] in_pos,
  input  wire logic [IDX_IN_BITS-1:0] in_tex,
  input  wire logic [IDX_IN_BITS-1:0] in_nrm,
  input  wire logic                   in_first,
  input  wire logic [MODE_BITS-1:0]   mode,
  output grp_t                        grp,
  output logic [2:0][2:0][VB-1:0]     face0,
  output logic [2:0][2:0][VB-1:0]     face1
);

  logic [CNT_BITS-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic [1:0]          mod3_r, mod3_nxt, mod3_eff;
  logic [2:0][VB-1:0]  rv0_r, rv1_r, rv2_r, anchor_r;
  logic [2:0][VB-1:0]  cur;
  logic                ge1, ge2;

  // Incoming vertex, masked to the index width.
  assign cur[F_POS] = in_pos[VB-1:0];
  assign cur[F_TEX] = in_tex[VB-1:0];
  assign cur[F_NRM] = in_nrm[VB-1:0];

  // A first-vertex mark restarts the count at zero.
  assign cnt_eff  = in_first ? '0 : cnt_r;
  assign mod3_eff = in_first ? 2'd0 : mod3_r;
  assign ge1      = (cnt_eff != '0);
  assign ge2      = (cnt_eff[CNT_BITS-1:1] != '0);

  // Stepping back by twelve keeps the value modulo 3 in step.
  assign cnt_nxt  = (cnt_eff == CNT_TOP) ? CNT_BACK : cnt_eff + 1'b1;
  assign mod3_nxt = (mod3_eff == 2'd2) ? 2'd0 : mod3_eff + 2'd1;

  // Count state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mod3_r <= 2'd0;
    end else if (in_fire) begin
      cnt_r  <= cnt_nxt;
      mod3_r <= mod3_nxt;
    end
  end

  // Vertex history; every slot is written before the count lets it be read.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rv2_r <= rv1_r;
      rv1_r <= rv0_r;
      rv0_r <= cur;
      if (cnt_eff == '0) begin
        anchor_r <= cur;
      end
    end
  end

  // Corner selection per mode.
  always_comb begin
    grp.has_face = 1'b0;
    grp.two      = 1'b0;
    grp.kind     = KIND_TRI;
    face0        = {cur, cur, cur};
    face1        = {cur, cur, cur};
    case (mode)
      MODE_LINES: begin
        grp.has_face = cnt_eff[0];
        grp.kind     = KIND_LINE;
        face0        = {cur, cur, rv0_r};
      end
      MODE_LINE_STRIP: begin
        grp.has_face = ge1;
        grp.kind     = KIND_LINE;
        face0        = {cur, cur, rv0_r};
      end
      MODE_TRIS: begin
        grp.has_face = (mod3_eff == 2'd2);
        face0        = {cur, rv0_r, rv1_r};
      end
      MODE_TRI_STRIP: begin
        grp.has_face = ge2;
        if (cnt_eff[0]) begin
          face0 = {rv0_r, cur, rv1_r};
        end else begin
          face0 = {cur, rv0_r, rv1_r};
        end
      end
      MODE_FAN: begin
        grp.has_face = ge2;
        face0        = {cur, rv0_r, anchor_r};
      end
      MODE_QUADS: begin
        grp.has_face = (cnt_eff[1:0] == 2'd3);
        grp.two      = 1'b1;
        face0        = {rv0_r, rv1_r, rv2_r};
        face1        = {cur, rv0_r, rv2_r};
      end
      default: begin
        grp.has_face = 1'b1;
        grp.kind     = KIND_POINT;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/pfa_emit.sv @@
// ---------------------------------------------------------------------------
// Face emitter
// Holds the faces of one vertex beat and drains them one per cycle, unless
// stalled, into the result register, adding offsets, clearing unused corner fields.
// ---------------------------------------------------------------------------
`default_nettype none

module pfa_emit
  import pfa_pkg::*;
#(
  parameter int VB = 16
)(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   grp_load,
  input  grp_t                        grp,
  input  wire logic [2:0][2:0][VB-1:0] face0,
  input  wire logic [2:0][2:0][VB-1:0] face1,
  input  cfg_t                        cfg,
  output logic                        grp_ready,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [287:0]                out_tdata,
  output logic                        out_tlast,
  output logic [1:0]                  out_tuser
);

  // Pending faces.
  logic                     pend_valid_r;
  logic                     pend_two_r;
  logic                     pend_sel_r;
  logic [KIND_BITS-1:0]     pend_kind_r;
  logic [2:0][2:0][VB-1:0]  pend_f0_r, pend_f1_r;

  // Result register.
  logic                     out_valid_r;
  logic [KIND_BITS-1:0]     out_kind_r;
  logic                     out_last_r;
  logic [8:0][OFFS_BITS-1:0] out_fields_r, fields_nxt;

  logic                     out_load, pend_last, pend_done;
  logic [2:0][2:0][VB-1:0]  sel_face;
  logic [2:0][OFFS_BITS-1:0] offs;

  assign pend_last = ~pend_two_r | pend_sel_r;
  assign out_load  = pend_valid_r & (~out_valid_r | out_tready);
  assign pend_done = out_load & pend_last;
  assign grp_ready = ~pend_valid_r | pend_done;
  assign sel_face  = pend_sel_r ? pend_f1_r : pend_f0_r;

  assign offs[F_POS] = cfg.vtx_off;
  assign offs[F_TEX] = cfg.tex_off;
  assign offs[F_NRM] = cfg.nrm_off;

  // Offset adders with per-kind field enables.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int f = 0; f < 3; f++) begin
        if ((c == 0 && f == F_POS) || (pend_kind_r == KIND_TRI) ||
            (pend_kind_r == KIND_LINE && c < 2 && f < 2)) begin
          fields_nxt[c*3+f] = {{(OFFS_BITS-VB){1'b0}}, sel_face[c][f]} + offs[f];
        end else begin
          fields_nxt[c*3+f] = '0;
        end
      end
    end
  end

  // Pending control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_sel_r   <= 1'b0;
    end else if (grp_load) begin
      pend_valid_r <= 1'b1;
      pend_sel_r   <= 1'b0;
    end else if (pend_done) begin
      pend_valid_r <= 1'b0;
    end else if (out_load) begin
      pend_sel_r   <= 1'b1;
    end
  end

  // Pending payload.
  always_ff @(posedge clk) begin
    if (grp_load) begin
      pend_two_r  <= grp.two;
      pend_kind_r <= grp.kind;
      pend_f0_r   <= face0;
      pend_f1_r   <= face1;
    end
  end

  // Result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r   <= pend_kind_r;
      out_last_r   <= pend_last;
      out_fields_r <= fields_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_fields_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_kind_r;

endmodule

`default_nettype wire

@@ rtl/primitive_to_face_assembly.sv @@
// ---------------------------------------------------------------------------
// Primitive-to-face assembly
// Groups a stream of vertex descriptors into line, triangle or point faces.
// ---------------------------------------------------------------------------
// One vertex beat is accepted per clock unless the emitter holds the input. A
// vertex produces at most one face, except the fourth vertex of a quad, which
// produces two; that beat holds the input until the second face moves into the
// single result register. All other modes take one vertex per cycle while the
// receiver keeps up. A face waits in the pending register after the edge that
// accepts its closing vertex, then moves into the result register. While the
// receiver stalls, the input stalls too as soon as a face is waiting behind the
// result register. Change the mode and offsets only while the block is idle.
`default_nettype none

module primitive_to_face_assembly
  import pfa_pkg::*;
#(
  parameter int INDEX_BITS = 16
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Vertex stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // position_index [15:0], texcoord_index [31:16], normal_index [47:32]
  input  wire logic [47:0] in_tdata,
  // first_vertex [0]
  input  wire logic [0:0]  in_tuser,
  // Face stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // a_position [31:0], a_texcoord [63:32], a_normal [95:64],
  // b_position [127:96], b_texcoord [159:128], b_normal [191:160],
  // c_position [223:192], c_texcoord [255:224], c_normal [287:256]
  output logic [287:0]     out_tdata,
  // last_of_run
  output logic             out_tlast,
  // face_kind [1:0]
  output logic [1:0]       out_tuser,
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // Stored index width: indices never exceed the input field width.
  localparam int VB = (INDEX_BITS < IDX_IN_BITS) ? INDEX_BITS : IDX_IN_BITS;

  cfg_t                    cfg;
  grp_t                    grp;
  logic [2:0][2:0][VB-1:0] face0, face1;
  logic                    in_fire, grp_load, grp_ready;

  assign in_tready = grp_ready;
  assign in_fire   = in_tvalid & in_tready;
  assign grp_load  = in_fire & grp.has_face;

  pfa_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pfa_assemble #(.VB(VB)) u_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_pos   (in_tdata[15:0]),
    .in_tex   (in_tdata[31:16]),
    .in_nrm   (in_tdata[47:32]),
    .in_first (in_tuser[0]),
    .mode     (cfg.mode),
    .grp      (grp),
    .face0    (face0),
    .face1    (face1)
  );

  pfa_emit #(.VB(VB)) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp_load   (grp_load),
    .grp        (grp),
    .face0      (face0),
    .face1      (face1),
    .cfg        (cfg),
    .grp_ready  (grp_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef ASSERT_OFF
  // The second face of a quad follows its first without a gap.
  a_quad_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("second quad face missing");

  // Only the first face of a quad comes without the last mark.
  a_nonlast_tri: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == KIND_TRI)
    else $error("non-final face is not a triangle");

  // Point faces carry only the first position.
  a_point_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_POINT |->
      out_tdata[287:32] == '0 && out_tlast)
    else $error("point face has extra fields");

  // Line faces carry no normals and no third corner.
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_LINE |->
      out_tdata[95:64] == '0 && out_tdata[287:160] == '0)
    else $error("line face has normal or third corner");
`endif

endmodule

`default_nettype wire
